### rtl/gregorian_date_difference_core_macros.svh
// ----------------------------------------------------------------------------
// Gregorian date difference: assertion macros
// Shared property forms for the checks at the end of the core.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_DIFFERENCE_CORE_MACROS_SVH
`define GREGORIAN_DATE_DIFFERENCE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GDD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

### rtl/gdd_pkg.sv
// ----------------------------------------------------------------------------
// Gregorian date difference package
// Field widths, calendar tables and the per-date pipeline step functions.
// ----------------------------------------------------------------------------
package gdd_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned COUNT_W = 22;
	localparam int unsigned QUOT_W  = 8;   // floor((year - 1) / 100) for a 14-bit year
	localparam int unsigned DBM_W   = 9;   // days before a month, up to 335
	localparam int unsigned PROD_W  = 27;  // 14-bit year times the 13-bit reciprocal

	localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
	localparam logic [12:0]        RECIP_100  = 13'd5243;  // ceil(2^19 / 100)
	localparam int unsigned        RECIP_SHR  = 19;
	localparam logic [6:0]         CENT_LAST  = 7'd99;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 22'd3652059;

	// Per-date state after the first stage.
	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  py;     // year - 1
		logic [QUOT_W-1:0]  qp;     // py / 100
		logic               ok;     // month and year in range
	} date_s1_t;

	// Per-date state after the second stage.
	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [DBM_W-1:0]   dbm;    // days before month, leap day included
		logic [COUNT_W-1:0] yd;     // 365 * py + py / 4
		logic [QUOT_W-1:0]  corr;   // py / 100 - py / 400
		logic               ok;     // whole date valid
	} date_s2_t;

	// Length of a month in a common year; zero for codes that are no month.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in the months before month m of a common year.
	function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		logic [DBM_W-1:0] n;
		unique case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

	// First stage: range checks and the century quotient by reciprocal multiply.
	// The reciprocal is exact for every 14-bit dividend.
	function automatic date_s1_t step_s1(input logic [DAY_W-1:0] d,
			input logic [MONTH_W-1:0] m, input logic [YEAR_W-1:0] y);
		date_s1_t         r;
		logic [PROD_W-1:0] prod;
		r.day   = d;
		r.month = m;
		r.py    = y - 14'd1;
		prod    = PROD_W'(r.py) * PROD_W'(RECIP_100);
		r.qp    = prod[RECIP_SHR +: QUOT_W];
		r.ok    = (y != '0) && (y <= YEAR_MAX) && (m != '0) && (m <= MONTH_DEC);
		return r;
	endfunction

	// Second stage: leap year, day check and the year part of the day number.
	// Year y is a leap year when py % 4 == 3 and py % 100 != 99, or when
	// py % 100 == 99 and (py / 100) % 4 == 3.
	function automatic date_s2_t step_s2(input date_s1_t s);
		date_s2_t          r;
		logic [YEAR_W-1:0] rem;
		logic              cent;
		logic              leap;
		logic [DAY_W-1:0]  len;
		rem  = s.py - YEAR_W'(s.qp) * 14'd100;
		cent = (rem[6:0] == CENT_LAST);
		leap = ((s.py[1:0] == 2'd3) && !cent) || (cent && (s.qp[1:0] == 2'd3));
		len  = (s.month == MONTH_FEB) ? (leap ? 5'd29 : 5'd28) : month_len(s.month);
		r.day  = s.day;
		r.dbm  = days_before(s.month) + DBM_W'(leap && (s.month > MONTH_FEB));
		r.yd   = COUNT_W'(s.py) * 22'd365 + COUNT_W'(s.py >> 2);
		r.corr = s.qp - (s.qp >> 2);
		r.ok   = s.ok && (s.day != '0) && (s.day <= len);
		return r;
	endfunction

	// Third stage: the day number, 1 January of year 1 being day 1.
	function automatic logic [COUNT_W-1:0] day_number(input date_s2_t s);
		return s.yd - COUNT_W'(s.corr) + COUNT_W'(s.dbm) + COUNT_W'(s.day);
	endfunction

endpackage

### rtl/gregorian_date_difference_core.sv
// ----------------------------------------------------------------------------
// Gregorian date difference core
// Counts the days between two proleptic Gregorian dates in a four-stage
// pipeline through closed-form day numbers.
// ----------------------------------------------------------------------------
//
// Channel   Direction   Handshake             Payload
// input     in          in_valid / in_stall   start_*, end_*, include_end
// output    out         out_valid / out_stall day_count, invalid_date
//
// Each transaction passes from acceptance to a valid result through the four
// register stages: century quotient, leap and year terms, day number, and the
// final subtract. A new transaction can enter every cycle while in_stall is low.
// Reset clears only the stage valid bits; the payload registers are not reset.
// A stage holds while the stage after it is full and stalled, so a stalled
// output backs up into in_stall, and empty stages still fill behind it.
// ----------------------------------------------------------------------------
`include "gregorian_date_difference_core_macros.svh"

module gregorian_date_difference_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [gdd_pkg::DAY_W-1:0]     start_day,
	input  logic [gdd_pkg::MONTH_W-1:0]   start_month,
	input  logic [gdd_pkg::YEAR_W-1:0]    start_year,
	input  logic [gdd_pkg::DAY_W-1:0]     end_day,
	input  logic [gdd_pkg::MONTH_W-1:0]   end_month,
	input  logic [gdd_pkg::YEAR_W-1:0]    end_year,
	input  logic                          include_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gdd_pkg::COUNT_W-1:0]   day_count,
	output logic                          invalid_date
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	gdd_pkg::date_s1_t a_s1, b_s1;
	logic              inc_s1;
	gdd_pkg::date_s2_t a_s2, b_s2;
	logic              inc_s2;
	logic [gdd_pkg::COUNT_W-1:0] na_s3, nb_s3;
	logic              inc_s3, bad_s3;
	logic [gdd_pkg::COUNT_W-1:0] count_s4;
	logic              bad_s4;

	// A stage loads when it is empty or its contents move on.
	assign en_s4    = !v_s4 || !out_stall;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: range checks and century quotients of both dates.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			a_s1   <= gdd_pkg::step_s1(start_day, start_month, start_year);
			b_s1   <= gdd_pkg::step_s1(end_day, end_month, end_year);
			inc_s1 <= include_end;
		end
	end

	// Stage 2: leap years, day checks and year terms.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			a_s2   <= gdd_pkg::step_s2(a_s1);
			b_s2   <= gdd_pkg::step_s2(b_s1);
			inc_s2 <= inc_s1;
		end
	end

	// Stage 3: day numbers.
	always_ff @(posedge clk) begin
		if (en_s3) begin
			na_s3  <= gdd_pkg::day_number(a_s2);
			nb_s3  <= gdd_pkg::day_number(b_s2);
			inc_s3 <= inc_s2;
			bad_s3 <= !a_s2.ok || !b_s2.ok;
		end
	end

	// Stage 4: difference, clamped at zero, plus the end day when asked; zero for an invalid date.
	always_ff @(posedge clk) begin
		if (en_s4) begin
			bad_s4 <= bad_s3;
			if (bad_s3) begin
				count_s4 <= '0;
			end else if (na_s3 < nb_s3) begin
				count_s4 <= nb_s3 - na_s3 + gdd_pkg::COUNT_W'(inc_s3);
			end else begin
				count_s4 <= gdd_pkg::COUNT_W'(inc_s3);
			end
		end
	end

	assign out_valid    = v_s4;
	assign day_count    = count_s4;
	assign invalid_date = bad_s4;

	// Checks on the pipeline and its results.
	`GDD_ASSERT_SAME(a_invalid_zero, out_valid && invalid_date, day_count == '0, "invalid date with nonzero count")
	`GDD_ASSERT_SAME(a_count_range, out_valid && !invalid_date, day_count <= gdd_pkg::COUNT_MAX + 22'd1, "day count out of range")
	`GDD_ASSERT_SAME(a_stall_full, in_stall, v_s1 && v_s2 && v_s3 && v_s4, "input stalled with an empty stage")
	`GDD_ASSERT_NEXT(a_stage_moves, v_s3 && en_s4, v_s4, "stage 3 transaction lost")

endmodule
